FILE: design/assert_macros.svh
// Assertion macros used by the converter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: expression does not hold");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: consequent missing on next cycle");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/bta_pkg.sv
// Shared constants and types of the binary to decimal ASCII converter.
package bta_pkg;

    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = DIGIT_W * BCD_DIGITS;
    localparam int CHAR_W     = 6;
    localparam int COUNT_W    = 4;
    localparam int BITCNT_W   = $clog2(VALUE_W);

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
    localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = 4'd5;
    localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_TRIM,
        ST_EMIT
    } state_t;

endpackage

FILE: design/bta_dabble_step.sv
// One double dabble step: add-3 adjust of every BCD digit, then shift in one bit.
module bta_dabble_step (
    input  logic [bta_pkg::BCD_W-1:0] bcd,
    input  logic                      bit_in,
    output logic [bta_pkg::BCD_W-1:0] bcd_next
);

    logic [bta_pkg::BCD_W-1:0] adjusted;

    always_comb
    begin
        for (int i = 0; i < bta_pkg::BCD_DIGITS; i++)
        begin
            if (bcd[i*bta_pkg::DIGIT_W +: bta_pkg::DIGIT_W] >= bta_pkg::ADJ_LIMIT)
            begin
                adjusted[i*bta_pkg::DIGIT_W +: bta_pkg::DIGIT_W] =
                    bcd[i*bta_pkg::DIGIT_W +: bta_pkg::DIGIT_W] + bta_pkg::ADJ_ADD;
            end
            else
            begin
                adjusted[i*bta_pkg::DIGIT_W +: bta_pkg::DIGIT_W] =
                    bcd[i*bta_pkg::DIGIT_W +: bta_pkg::DIGIT_W];
            end
        end
        bcd_next = {adjusted[bta_pkg::BCD_W-2:0], bit_in};
    end

endmodule

FILE: design/binary_to_decimal_ascii_top.sv
// Binary to decimal ASCII converter: sequencer around a shared double dabble step.
// Operation: a 32-step bit-serial double dabble conversion, then leading zero
// digits are stripped (at least one is kept), then one digit per output transfer.
// A new value is taken only in idle, once the last digit of the previous one is
// sent; the 32-step conversion loop through the single adjust/shift unit dominates.
// Reset (rst_n low, asynchronous) returns the sequencer to idle; no data is kept.
`include "assert_macros.svh"
module binary_to_decimal_ascii_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bta_pkg::VALUE_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bta_pkg::CHAR_W-1:0]    ascii_char,
    output logic [bta_pkg::COUNT_W-1:0]   digit_count,
    output logic                          last_digit
);

    localparam logic [bta_pkg::BITCNT_W-1:0] BIT_LAST = bta_pkg::BITCNT_W'(bta_pkg::VALUE_W - 1);
    localparam logic [bta_pkg::COUNT_W-1:0]  FULL_DIGITS = bta_pkg::COUNT_W'(bta_pkg::BCD_DIGITS);
    localparam logic [bta_pkg::COUNT_W-1:0]  ONE_DIGIT = bta_pkg::COUNT_W'(1);

    bta_pkg::state_t                 state_reg, state_next;
    logic [bta_pkg::VALUE_W-1:0]     bin_reg, bin_next;
    logic [bta_pkg::BCD_W-1:0]       bcd_reg, bcd_next;
    logic [bta_pkg::BITCNT_W-1:0]    bitcnt_reg, bitcnt_next;
    logic [bta_pkg::COUNT_W-1:0]     ndig_reg, ndig_next;
    logic [bta_pkg::COUNT_W-1:0]     left_reg, left_next;
    logic [bta_pkg::BCD_W-1:0]       step_bcd;
    logic [bta_pkg::DIGIT_W-1:0]     top_digit;

    bta_dabble_step u_step (
        .bcd      (bcd_reg),
        .bit_in   (bin_reg[bta_pkg::VALUE_W-1]),
        .bcd_next (step_bcd)
    );

    assign top_digit = bcd_reg[bta_pkg::BCD_W-1 -: bta_pkg::DIGIT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bta_pkg::ST_IDLE;
            bitcnt_reg <= '0;
            ndig_reg   <= '0;
            left_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            bitcnt_reg <= bitcnt_next;
            ndig_reg   <= ndig_next;
            left_reg   <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        bin_next    = bin_reg;
        bcd_next    = bcd_reg;
        bitcnt_next = bitcnt_reg;
        ndig_next   = ndig_reg;
        left_next   = left_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;

        unique case (state_reg)
            bta_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    bin_next    = value;
                    bcd_next    = '0;
                    bitcnt_next = '0;
                    state_next  = bta_pkg::ST_CONVERT;
                end
            end
            bta_pkg::ST_CONVERT:
            begin
                bcd_next    = step_bcd;
                bin_next    = {bin_reg[bta_pkg::VALUE_W-2:0], 1'b0};
                bitcnt_next = bitcnt_reg + 1'b1;
                if (bitcnt_reg == BIT_LAST)
                begin
                    ndig_next  = FULL_DIGITS;
                    state_next = bta_pkg::ST_TRIM;
                end
            end
            bta_pkg::ST_TRIM:
            begin
                // drop leading zero digits, keep at least one
                if (top_digit == '0 && ndig_reg != ONE_DIGIT)
                begin
                    bcd_next  = {bcd_reg[bta_pkg::BCD_W-bta_pkg::DIGIT_W-1:0],
                                 {bta_pkg::DIGIT_W{1'b0}}};
                    ndig_next = ndig_reg - 1'b1;
                end
                else
                begin
                    left_next  = ndig_reg;
                    state_next = bta_pkg::ST_EMIT;
                end
            end
            bta_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    bcd_next  = {bcd_reg[bta_pkg::BCD_W-bta_pkg::DIGIT_W-1:0],
                                 {bta_pkg::DIGIT_W{1'b0}}};
                    left_next = left_reg - 1'b1;
                    if (left_reg == ONE_DIGIT)
                    begin
                        state_next = bta_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = bta_pkg::ST_IDLE;
            end
        endcase
    end

    assign ascii_char  = bta_pkg::ASCII_ZERO | {2'b00, top_digit};
    assign digit_count = ndig_reg;
    assign last_digit  = (left_reg == ONE_DIGIT);

    `ASSERT_ALWAYS(a_digit_decimal, clk, rst_n, !out_valid || top_digit <= bta_pkg::DIGIT_MAX)
    `ASSERT_ALWAYS(a_count_range, clk, rst_n, !out_valid || (ndig_reg != '0 && ndig_reg <= FULL_DIGITS))
    `ASSERT_ALWAYS(a_no_overlap, clk, rst_n, !(in_ready && out_valid))
    `ASSERT_ALWAYS(a_left_bound, clk, rst_n, !out_valid || (left_reg != '0 && left_reg <= ndig_reg))
    `ASSERT_NEXT(a_last_to_idle, clk, rst_n, out_valid && out_ready && last_digit, in_ready)

endmodule
